### hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_CHK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`endif

### hw/rtl/ebk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ebk_pkg;

  localparam int TimeWidthDefault = 32;
  localparam int OutTimeWidth     = 32;
  localparam int CfgIdxWidth      = 3;
  localparam int CfgDataWidth     = 16;

  localparam logic [CfgIdxWidth-1:0] REG_TICK_DIVISOR    = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_ON_STEPS        = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_OFF_STEPS       = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_PAUSE_STEPS     = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_MICROS_PER_TICK = 3'd4;

  localparam logic [7:0]  RST_TICK_DIVISOR    = 8'd164;
  localparam logic [7:0]  RST_ON_STEPS        = 8'd18;
  localparam logic [7:0]  RST_OFF_STEPS       = 8'd18;
  localparam logic [7:0]  RST_PAUSE_STEPS     = 8'd80;
  localparam logic [15:0] RST_MICROS_PER_TICK = 16'd100;

  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_ON    = 2'd1;
  localparam logic [1:0] PH_OFF   = 2'd2;
  localparam logic [1:0] PH_PAUSE = 2'd3;

  localparam logic [7:0] BLINKS_MAX = 8'd255;

  typedef struct packed {
    logic       step;
    logic       set;
    logic [7:0] code;
  } ebk_seq_ctl_t;

  typedef struct packed {
    logic [7:0] on_steps;
    logic [7:0] off_steps;
    logic [7:0] pause_steps;
  } ebk_timing_t;

  typedef struct packed {
    logic       led;
    logic [7:0] code;
  } ebk_seq_stat_t;

endpackage
`default_nettype wire

### hw/rtl/error_code_blinker.sv
// An accepted beat's result is registered and presented in the next cycle.
// Throughput: one beat per cycle; input stalls only while a held result is stalled.
// Prescaler, time counter advance on accepted tick beats; sequencer only on accepts.
// Reset: synchronous, active low; clears state, output valid, loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module error_code_blinker
  import ebk_pkg::*;
#(
  parameter int TIME_WIDTH = TimeWidthDefault
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic [7:0]              in_error_code,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_led_on,
  output logic [7:0]              out_current_code,
  output logic [OutTimeWidth-1:0] out_elapsed_micros
);

  logic [7:0]  tick_divisor_r, on_steps_r, off_steps_r, pause_steps_r;
  logic [15:0] micros_per_tick_r;

  logic [7:0]            prescale_r, prescale_nxt, prescale_inc;
  logic [TIME_WIDTH-1:0] time_r, time_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_led_r;
  logic [7:0]              out_code_r;
  logic [OutTimeWidth-1:0] out_time_r;

  logic          accept, tick;
  ebk_seq_ctl_t  seq_ctl;
  ebk_timing_t   timing;
  ebk_seq_stat_t seq_stat;

  assign in_stall      = out_valid_r & out_stall;
  assign accept        = in_valid & ~in_stall;
  assign tick          = accept & ~in_command;
  assign out_valid_nxt = accept | in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_divisor_r    <= RST_TICK_DIVISOR;
      on_steps_r        <= RST_ON_STEPS;
      off_steps_r       <= RST_OFF_STEPS;
      pause_steps_r     <= RST_PAUSE_STEPS;
      micros_per_tick_r <= RST_MICROS_PER_TICK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICK_DIVISOR:    tick_divisor_r    <= cfg_data[7:0];
        REG_ON_STEPS:        on_steps_r        <= cfg_data[7:0];
        REG_OFF_STEPS:       off_steps_r       <= cfg_data[7:0];
        REG_PAUSE_STEPS:     pause_steps_r     <= cfg_data[7:0];
        REG_MICROS_PER_TICK: micros_per_tick_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prescale_inc = prescale_r + 8'd1;
    prescale_nxt = prescale_r;
    time_nxt     = time_r;
    seq_ctl.step = 1'b0;
    seq_ctl.set  = accept & in_command;
    seq_ctl.code = in_error_code;
    if (tick) begin
      time_nxt = time_r + TIME_WIDTH'(micros_per_tick_r);
      if (prescale_inc >= tick_divisor_r) begin
        prescale_nxt = 8'd0;
        seq_ctl.step = 1'b1;
      end else begin
        prescale_nxt = prescale_inc;
      end
    end
  end

  assign timing.on_steps    = on_steps_r;
  assign timing.off_steps   = off_steps_r;
  assign timing.pause_steps = pause_steps_r;

  ebk_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (seq_ctl),
    .timing   (timing),
    .stat_nxt (seq_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r  <= 8'd0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prescale_r  <= prescale_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_led_r  <= seq_stat.led;
      out_code_r <= seq_stat.code;
      out_time_r <= OutTimeWidth'(time_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_led_on         = out_led_r;
  assign out_current_code   = out_code_r;
  assign out_elapsed_micros = out_time_r;

endmodule
`default_nettype wire

### hw/rtl/ebk_seq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ebk_seq
  import ebk_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  ebk_seq_ctl_t  ctl,
  input  ebk_timing_t   timing,
  output ebk_seq_stat_t stat_nxt
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] steps_left_r, steps_left_nxt;
  logic [7:0] blinks_done_r, blinks_done_nxt;
  logic [7:0] code_r, code_nxt;
  logic       led_r, led_nxt;

  always_comb begin
    phase_nxt       = phase_r;
    steps_left_nxt  = steps_left_r;
    blinks_done_nxt = blinks_done_r;
    code_nxt        = code_r;
    led_nxt         = led_r;
    if (ctl.set) begin
      code_nxt = ctl.code;
      if (ctl.code == 8'd0) begin
        phase_nxt = PH_NONE;
        led_nxt   = 1'b0;
      end else if (ctl.code != code_r) begin
        phase_nxt = PH_OFF;
        led_nxt   = 1'b0;
      end
    end else if (ctl.step) begin
      if (steps_left_r != 8'd0) begin
        steps_left_nxt = steps_left_r - 8'd1;
      end else begin
        unique case (phase_r)
          PH_ON: begin
            if (blinks_done_r != BLINKS_MAX) begin
              blinks_done_nxt = blinks_done_r + 8'd1;
            end
            phase_nxt      = PH_OFF;
            steps_left_nxt = timing.off_steps;
            led_nxt        = 1'b0;
          end
          PH_OFF: begin
            if (blinks_done_r >= code_r) begin
              phase_nxt      = PH_PAUSE;
              steps_left_nxt = timing.pause_steps;
            end else begin
              phase_nxt      = PH_ON;
              steps_left_nxt = timing.on_steps;
              led_nxt        = 1'b1;
            end
          end
          PH_PAUSE: begin
            blinks_done_nxt = 8'd0;
            phase_nxt       = PH_ON;
            steps_left_nxt  = timing.on_steps;
            led_nxt         = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_NONE;
      steps_left_r  <= 8'd0;
      blinks_done_r <= 8'd0;
      code_r        <= 8'd0;
      led_r         <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      steps_left_r  <= steps_left_nxt;
      blinks_done_r <= blinks_done_nxt;
      code_r        <= code_nxt;
      led_r         <= led_nxt;
    end
  end

  assign stat_nxt.led  = led_nxt;
  assign stat_nxt.code = code_nxt;

  `ASSERT_NEVER(a_led_only_on, clk, rst_n, led_r && (phase_r != PH_ON), "LED lit outside on phase")
  `ASSERT_CHK(a_zero_code_idle, clk, rst_n, (code_r == 8'd0) |-> (phase_r == PH_NONE), "code zero not idle")
  `ASSERT_CHK(a_clear_led_off, clk, rst_n, (ctl.set && (ctl.code == 8'd0)) |=> !led_r, "clear left LED lit")

endmodule
`default_nettype wire
